@@ rtl/cc20_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cc20_pkg: shared types and constants for the ChaCha20 stream cipher
// Register indexes, cipher constants, quarter-round schedule, control structs.
// ----------------------------------------------------------------------------
package cc20_pkg;

  localparam int DOUBLE_ROUNDS = 10;
  localparam int RoundBits     = 5;  // counts 2*DOUBLE_ROUNDS rounds

  localparam logic [31:0] SIGMA0 = 32'h61707865;
  localparam logic [31:0] SIGMA1 = 32'h3320646e;
  localparam logic [31:0] SIGMA2 = 32'h79622d32;
  localparam logic [31:0] SIGMA3 = 32'h6b206574;

  // configuration register indexes
  localparam logic [2:0] REG_KEY0    = 3'd0;
  localparam logic [2:0] REG_KEY1    = 3'd1;
  localparam logic [2:0] REG_KEY2    = 3'd2;
  localparam logic [2:0] REG_KEY3    = 3'd3;
  localparam logic [2:0] REG_NONCE0  = 3'd4;
  localparam logic [2:0] REG_NONCE1  = 3'd5;
  localparam logic [2:0] REG_START   = 3'd6;

  // controller -> datapath
  typedef struct packed {
    logic       load_init;   // copy initial state into work state
    logic       qr_en;       // run one quarter round
    logic       diag;        // diagonal round when set
    logic [1:0] qr_sel;      // which of the four quarter rounds
    logic       feed_fwd;    // keystream = work + init
    logic       load_ctr;    // block counter <- start counter
    logic       inc_ctr;     // block counter + 1
  } cc20_cmd_t;

  // four state indexes of one quarter round
  function automatic logic [15:0] qr_index(input logic diag, input logic [1:0] sel);
    logic [3:0] a, b, c, d;
    a = {2'b00, sel};
    if (!diag) begin
      b = {2'b01, sel};
      c = {2'b10, sel};
      d = {2'b11, sel};
    end else begin
      b = {2'b01, sel + 2'd1};
      c = {2'b10, sel + 2'd2};
      d = {2'b11, sel + 2'd3};
    end
    return {d, c, b, a};
  endfunction

endpackage

@@ rtl/cc20_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cc20_datapath: state, one shared quarter-round unit and keystream store
// Holds the work and keystream words, block counter, and XORs message words.
// ----------------------------------------------------------------------------
module cc20_datapath (
  input  logic                clk,
  input  cc20_pkg::cc20_cmd_t cmd,
  input  logic [255:0]        key,
  input  logic [95:0]         nonce,
  input  logic [31:0]         start_counter,
  input  logic [3:0]          word_pos,
  input  logic [31:0]         data_in,
  input  logic [2:0]          byte_count,
  output logic [31:0]         data_xor
);

  logic [31:0] work [16];
  logic [31:0] ks   [16];
  logic [31:0] init [16];
  logic [31:0] block_counter;
  logic [15:0] idx;
  logic [31:0] a0, b0, c0, d0, a1, b1, c1, d1, a2, b2, c2, d2;
  logic [31:0] mask;

  // initial state
  always_comb begin
    init[0] = cc20_pkg::SIGMA0;
    init[1] = cc20_pkg::SIGMA1;
    init[2] = cc20_pkg::SIGMA2;
    init[3] = cc20_pkg::SIGMA3;
    for (int i = 0; i < 8; i++) init[4+i] = key[32*i +: 32];
    init[12] = block_counter;
    init[13] = nonce[31:0];
    init[14] = nonce[63:32];
    init[15] = nonce[95:64];
  end

  // quarter round on the selected column or diagonal
  always_comb begin
    idx = cc20_pkg::qr_index(cmd.diag, cmd.qr_sel);
    a0 = work[idx[3:0]] + work[idx[7:4]];
    d0 = work[idx[15:12]] ^ a0; d0 = {d0[15:0], d0[31:16]};
    c0 = work[idx[11:8]] + d0;
    b0 = work[idx[7:4]] ^ c0;   b0 = {b0[19:0], b0[31:20]};
    a1 = a0 + b0;
    d1 = d0 ^ a1;               d1 = {d1[23:0], d1[31:24]};
    c1 = c0 + d1;
    b1 = b0 ^ c1;               b1 = {b1[24:0], b1[31:25]};
    a2 = a1; b2 = b1; c2 = c1; d2 = d1;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_ctr) begin
      block_counter <= start_counter;
    end else if (cmd.inc_ctr) begin
      block_counter <= block_counter + 32'd1;
    end
    if (cmd.load_init) begin
      for (int i = 0; i < 16; i++) work[i] <= init[i];
    end else if (cmd.qr_en) begin
      work[idx[3:0]]   <= a2;
      work[idx[7:4]]   <= b2;
      work[idx[11:8]]  <= c2;
      work[idx[15:12]] <= d2;
    end
    if (cmd.feed_fwd) begin
      for (int i = 0; i < 16; i++) ks[i] <= work[i] + init[i];
    end
  end

  // output word, bytes past the count zeroed
  always_comb begin
    unique case (byte_count)
      3'd0:    mask = 32'h0000_0000;
      3'd1:    mask = 32'h0000_00ff;
      3'd2:    mask = 32'h0000_ffff;
      3'd3:    mask = 32'h00ff_ffff;
      default: mask = 32'hffff_ffff;
    endcase
    data_xor = (data_in ^ ks[word_pos]) & mask;
  end

endmodule

@@ rtl/cc20_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cc20_ctrl: sequencer for block generation and word handshakes
// Steps the quarter-round schedule and tracks message and word position.
// ----------------------------------------------------------------------------
module cc20_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                last_word,
  input  logic                out_stall,
  output logic                out_valid,
  output logic                capture,
  output logic [3:0]          word_pos,
  output cc20_pkg::cc20_cmd_t cmd
);

  typedef enum logic [1:0] {S_IDLE, S_INIT, S_ROUND, S_FEED} state_t;

  state_t                      state;
  logic                        message_active;
  logic                        block_ready;
  logic [cc20_pkg::RoundBits-1:0] round;
  logic [1:0]                  qr;
  logic                        out_free;

  localparam logic [cc20_pkg::RoundBits-1:0] LastRound =
    cc20_pkg::RoundBits'(2 * cc20_pkg::DOUBLE_ROUNDS - 1);

  assign out_free = !out_valid || !out_stall;
  assign in_stall = !(state == S_IDLE && message_active && block_ready && out_free);
  assign capture  = in_valid && !in_stall;

  always_comb begin
    cmd          = '0;
    cmd.diag     = round[0];
    cmd.qr_sel   = qr;
    cmd.load_ctr = (state == S_IDLE) && in_valid && !message_active;
    cmd.load_init = (state == S_INIT);
    cmd.qr_en    = (state == S_ROUND);
    cmd.feed_fwd = (state == S_FEED);
    cmd.inc_ctr  = capture && word_pos == 4'd15 && !last_word;
  end

  // sequencer, message tracking, output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      message_active <= 1'b0;
      block_ready    <= 1'b0;
      word_pos       <= '0;
      round          <= '0;
      qr             <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_valid && !message_active) begin
            message_active <= 1'b1;
            word_pos       <= '0;
            block_ready    <= 1'b0;
          end else if (in_valid && !block_ready) begin
            state <= S_INIT;
          end else if (capture) begin
            out_valid <= 1'b1;
            word_pos  <= word_pos + 4'd1;
            if (word_pos == 4'd15) block_ready <= 1'b0;
            if (last_word) begin
              message_active <= 1'b0;
              block_ready    <= 1'b0;
              word_pos       <= '0;
            end
          end
        end
        S_INIT: begin
          round <= '0;
          qr    <= '0;
          state <= S_ROUND;
        end
        S_ROUND: begin
          qr <= qr + 2'd1;
          if (qr == 2'd3) begin
            round <= round + 1'b1;
            if (round == LastRound) state <= S_FEED;
          end
        end
        default: begin
          block_ready <= 1'b1;
          state       <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ rtl/chacha20_stream_cipher.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chacha20_stream_cipher: ChaCha20 word cipher with a shared quarter-round unit
//
//   channel   signals                                  handshake
//   input     data_in, byte_count, last_word           valid / stall
//   output    data_out, out_byte_count, out_last       valid / stall
//   config    cfg_index, cfg_data                      cfg_valid / cfg_ready
//
// Words within a block are taken back to back while the output is free. The
// first word of a block waits for the block, computed in the init, round and
// feed states by the single quarter-round unit; the first word of a message
// also waits while the block counter loads. Reset is synchronous and clears
// control state and the configuration registers. A stalled output holds its
// item; one new word is taken while the output drains.
// ----------------------------------------------------------------------------
module chacha20_stream_cipher (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] data_in,
  input  logic [2:0]  byte_count,
  input  logic        last_word,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] data_out,
  output logic [2:0]  out_byte_count,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  logic [255:0]        key;
  logic [95:0]         nonce;
  logic [31:0]         start_counter;
  logic                capture;
  logic [3:0]          word_pos;
  logic [31:0]         data_xor;
  cc20_pkg::cc20_cmd_t cmd;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      key           <= '0;
      nonce         <= '0;
      start_counter <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        cc20_pkg::REG_KEY0:   key[63:0]     <= cfg_data;
        cc20_pkg::REG_KEY1:   key[127:64]   <= cfg_data;
        cc20_pkg::REG_KEY2:   key[191:128]  <= cfg_data;
        cc20_pkg::REG_KEY3:   key[255:192]  <= cfg_data;
        cc20_pkg::REG_NONCE0: nonce[63:0]   <= cfg_data;
        cc20_pkg::REG_NONCE1: nonce[95:64]  <= cfg_data[31:0];
        cc20_pkg::REG_START:  start_counter <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  cc20_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .last_word (last_word),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .capture   (capture),
    .word_pos  (word_pos),
    .cmd       (cmd)
  );

  cc20_datapath u_dp (
    .clk           (clk),
    .cmd           (cmd),
    .key           (key),
    .nonce         (nonce),
    .start_counter (start_counter),
    .word_pos      (word_pos),
    .data_in       (data_in),
    .byte_count    (byte_count),
    .data_xor      (data_xor)
  );

  // output register
  always_ff @(posedge clk) begin
    if (capture) begin
      data_out       <= data_xor;
      out_byte_count <= byte_count;
      out_last       <= last_word;
    end
  end

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the ChaCha20 stream cipher
// A class-based keystream predictor tracks key, nonce and block counter and
// queues the expected ciphertext words; random messages run under varied
// input gaps and output stalls, with configuration changed between phases.
// ----------------------------------------------------------------------------
module testbench;

  typedef struct packed {
    logic [31:0] data;
    logic [2:0]  cnt;
    logic        last;
  } word_t;

  // keystream predictor and queue of expected cipher words
  class cipher_scoreboard;
    logic [63:0] key_q[4];
    logic [63:0] nonce_lo;
    logic [31:0] nonce_hi;
    logic [31:0] start_ctr;
    logic [31:0] ks_words[16];
    logic [3:0]  pos;
    logic [31:0] blk_ctr;
    bit          have_block;
    bit          in_message;
    word_t       cipher_q[$];
    int          mismatches;

    function void reset_state();
      foreach (key_q[i]) key_q[i] = '0;
      nonce_lo = '0; nonce_hi = '0; start_ctr = '0;
      pos = '0; blk_ctr = '0; have_block = 0; in_message = 0;
      mismatches = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [63:0] val);
      case (idx)
        cc20_pkg::REG_KEY0:   key_q[0] = val;
        cc20_pkg::REG_KEY1:   key_q[1] = val;
        cc20_pkg::REG_KEY2:   key_q[2] = val;
        cc20_pkg::REG_KEY3:   key_q[3] = val;
        cc20_pkg::REG_NONCE0: nonce_lo = val;
        cc20_pkg::REG_NONCE1: nonce_hi = val[31:0];
        cc20_pkg::REG_START:  start_ctr = val[31:0];
        default: ;  // unmapped index, no effect
      endcase
    endfunction

    function logic [31:0] rotl(logic [31:0] v, int n);
      return (v << n) | (v >> (32 - n));
    endfunction

    function void qround(ref logic [31:0] s[16], input int a, int b, int c, int d);
      s[a] += s[b]; s[d] = rotl(s[d] ^ s[a], 16);
      s[c] += s[d]; s[b] = rotl(s[b] ^ s[c], 12);
      s[a] += s[b]; s[d] = rotl(s[d] ^ s[a], 8);
      s[c] += s[d]; s[b] = rotl(s[b] ^ s[c], 7);
    endfunction

    function void build_block();
      logic [31:0] init[16];
      logic [31:0] w[16];
      init[0] = cc20_pkg::SIGMA0; init[1] = cc20_pkg::SIGMA1;
      init[2] = cc20_pkg::SIGMA2; init[3] = cc20_pkg::SIGMA3;
      for (int i = 0; i < 8; i++)
        init[4 + i] = (i % 2) ? key_q[i / 2][63:32] : key_q[i / 2][31:0];
      init[12] = blk_ctr;
      init[13] = nonce_lo[31:0];
      init[14] = nonce_lo[63:32];
      init[15] = nonce_hi;
      w = init;
      for (int r = 0; r < cc20_pkg::DOUBLE_ROUNDS; r++) begin
        qround(w, 0, 4, 8, 12);  qround(w, 1, 5, 9, 13);
        qround(w, 2, 6, 10, 14); qround(w, 3, 7, 11, 15);
        qround(w, 0, 5, 10, 15); qround(w, 1, 6, 11, 12);
        qround(w, 2, 7, 8, 13);  qround(w, 3, 4, 9, 14);
      end
      for (int i = 0; i < 16; i++) ks_words[i] = w[i] + init[i];
    endfunction

    // accepted input word -> expected output word
    function void note_input(logic [31:0] d, logic [2:0] c, logic l);
      word_t e;
      logic [31:0] mask;
      if (!in_message) begin
        blk_ctr = start_ctr; pos = '0; in_message = 1; have_block = 0;
      end
      if (!have_block) begin
        build_block();
        have_block = 1;
      end
      mask = (c >= 3'd4) ? 32'hFFFF_FFFF : ((32'd1 << (8 * c)) - 32'd1);
      e.data = (d ^ ks_words[pos]) & mask;
      e.cnt = c;
      e.last = l;
      cipher_q.push_back(e);
      pos++;
      if (pos == 0) begin
        have_block = 0;
        blk_ctr++;
      end
      if (l) begin
        in_message = 0; have_block = 0; pos = '0;
      end
    endfunction

    function void check_output(logic [31:0] d, logic [2:0] c, logic l);
      word_t e;
      if (cipher_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: unexpected item data=%h cnt=%0d last=%0b", d, c, l);
        return;
      end
      e = cipher_q.pop_front();
      if (e.data !== d || e.cnt !== c || e.last !== l) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: exp data=%h cnt=%0d last=%0b, got data=%h cnt=%0d last=%0b",
                   e.data, e.cnt, e.last, d, c, l);
      end
    endfunction

    function int pending();
      return cipher_q.size();
    endfunction
  endclass

  localparam int CycleLimit = 3_000_000;
  localparam int DrainCycles = 120;  // beyond one block computation

  logic        clk = 0;
  logic        rst = 1;
  logic        in_valid = 0;
  logic        in_stall;
  logic [31:0] data_in = '0;
  logic [2:0]  byte_count = 3'd4;
  logic        last_word = 0;
  logic        out_valid;
  logic        out_stall = 0;
  logic [31:0] data_out;
  logic [2:0]  out_byte_count;
  logic        out_last;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;

  cipher_scoreboard sb;
  int send_gap_pct = 0;
  int recv_stall_pct = 0;
  int hold_cycles = 0;
  int cycle_cnt = 0;

  chacha20_stream_cipher u_dut (
    .clk, .rst, .in_valid, .in_stall, .data_in, .byte_count, .last_word,
    .out_valid, .out_stall, .data_out, .out_byte_count, .out_last,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  always #6 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // receiver stalls: random, plus a counted long hold-off
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // output monitor
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_output(data_out, out_byte_count, out_last);
  end

  task automatic send_word(logic [31:0] d, logic [2:0] c, logic l);
    @(negedge clk);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    data_in <= d;
    byte_count <= c;
    last_word <= l;
    do @(posedge clk); while (in_stall);
    sb.note_input(d, c, l);
  endtask

  task automatic end_burst();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic write_reg(logic [2:0] idx, logic [63:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, val);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (sb.pending() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // one message of random words; mostly well formed, some noisy counts
  task automatic send_message(int len);
    logic [2:0] c;
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(99) < 8) c = 3'($urandom_range(7));
      else if (i == len - 1) c = 3'($urandom_range(4, 1));
      else c = 3'd4;
      send_word($urandom, c, i == len - 1);
    end
  endtask

  task automatic load_config(int mode);
    logic [63:0] v;
    for (int i = 0; i < 7; i++) begin
      case (mode)
        0: v = '0;
        1: v = '1;
        default: v = {$urandom, $urandom};
      endcase
      // counter wraps in message
      if (i == cc20_pkg::REG_START && mode == 3) v = 64'hFFFF_FFFE;
      write_reg(i[2:0], v);
    end
  endtask

  initial begin
    int sent;
    int len;
    sb = new();
    sb.reset_state();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: counts, last placement, block crossing
    load_config(0);
    send_word(32'hFFFF_FFFF, 3'd4, 1'b1);
    for (int c = 0; c < 8; c++) send_word(c[0] ? 32'hFFFF_FFFF : 32'h0, c[2:0], 1'b0);
    for (int i = 0; i < 10; i++) send_word($urandom, 3'd4, 1'b0);
    send_word(32'hA5A5_5A5A, 3'd2, 1'b1);
    end_burst();
    wait_drained();
    load_config(1);
    write_reg(3'd7, '1);  // unmapped register
    for (int i = 0; i < 4; i++) send_word(32'h0, 3'd4, i == 3);
    send_word(32'h1234_5678, 3'd1, 1'b0);  // message left open across config
    end_burst();
    wait_drained();

    // random phases
    for (int ph = 0; ph < 6; ph++) begin
      send_gap_pct = (ph < 2) ? 34 : (ph < 4) ? 81 : 0;
      recv_stall_pct = (ph < 2) ? 81 : (ph < 4) ? 34 : 0;
      load_config((ph == 3) ? 3 : 2);
      if (ph == 1 || ph == 4) hold_cycles = 400;
      sent = 0;
      while (sent < 140) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(70, 33) : $urandom_range(20, 1);
        send_message(len);
        sent += len;
        if (ph == 2 && sent > 80 && sent - len <= 80) begin
          end_burst();
          while (sb.pending() != 0) @(posedge clk);
        end
      end
      send_message($urandom_range(5, 1) + 16);
      end_burst();
      wait_drained();
    end

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule

@@ filelist.f @@
rtl/cc20_pkg.sv
rtl/cc20_datapath.sv
rtl/cc20_ctrl.sv
rtl/chacha20_stream_cipher.sv
verif/testbench.sv
